// File: rtl/core/fptw_pkg.sv
package fptw_pkg;

   // function codes of a request word
   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_ENTRY     = 1'b1;

   // kind codes of a response word
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam int unsigned PA_W = 52;
   localparam int unsigned VA_W = 48;
   localparam int unsigned PTE_W = 64;
   localparam int unsigned IDX_W = 9;

   // page size bit of a table entry
   localparam int unsigned PS_BIT = 7;

   typedef struct packed {
      logic              func;
      logic [VA_W-1:0]   vaddr;
      logic [PTE_W-1:0]  entry_data;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [PA_W-1:0]  read_addr;
      logic [PA_W-1:0]  paddr;
      logic             fault;
   } rsp_type;

   // classified word as it sits in the queue
   typedef struct packed {
      logic              is_entry;
      logic              entry_zero;
      logic              page_size;
      logic [VA_W-1:0]   vaddr;
      logic [PTE_W-1:0]  entry_data;
   } item_type;

   // handshake of the queue write side
   typedef struct packed {
      logic valid;
      logic ready;
   } push_ctl_type;

endpackage

// File: rtl/core/four_level_page_table_walker_top.sv
// Four-level page table walker for 48-bit virtual addresses.
// Request channel (req_): a word either starts a translation (func
// translate, vaddr) or returns a table entry read from memory
// (func entry, entry_data). Response channel (rsp_): a word is either a
// memory read request for an 8-byte entry (kind read, read_addr) or a
// finished translation (kind done, paddr, fault).
// csr_write_enable/csr_write_data load the top-level table base; zero
// disables translation. Write it only while the walker is idle.
// Throughput: one request word per cycle while the queue has room. Words
// pass a small queue, then the walker takes each from the head and loads
// its response register, stepping once per cycle unless that register
// holds a word not yet taken. Unmatched words (a translate during a
// walk, an entry while idle) are dropped without a response.
// When rsp_ready is low the response register holds its word; the queue
// keeps taking requests until QUEUE_DEPTH words wait, then req_ready
// falls. Reset empties the queue, returns the walker to idle and clears
// the table base.
module four_level_page_table_walker_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fptw_pkg::req_type           req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fptw_pkg::rsp_type           rsp_word,
   input  logic                        csr_write_enable,
   input  logic [fptw_pkg::PA_W-1:0]   csr_write_data
);
   import fptw_pkg::*;

   logic [PA_W-1:0] table_base_ff;
   push_ctl_type    push_ctl;
   item_type        push_item;
   item_type        pop_item;
   logic            queue_ready;
   logic            pop_valid;
   logic            pop_ready;

   // hold the table base register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
      end else if (csr_write_enable) begin
         table_base_ff <= csr_write_data;
      end
   end

   fptw_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .queue_ready (queue_ready),
      .push_ctl    (push_ctl),
      .push_item   (push_item)
   );

   fptw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_ctl   (push_ctl),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   fptw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .table_base (table_base_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

// File: rtl/core/fptw_front.sv
module fptw_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fptw_pkg::req_type     req_word,
   input  logic                  queue_ready,
   output fptw_pkg::push_ctl_type push_ctl,
   output fptw_pkg::item_type    push_item
);
   import fptw_pkg::*;

   // accept whenever the queue has room
   assign req_ready      = queue_ready;
   assign push_ctl.valid = req_valid;
   assign push_ctl.ready = queue_ready;

   // classify the word ahead of the walker
   always_comb begin
      push_item.is_entry   = (req_word.func == FUNC_ENTRY);
      push_item.entry_zero = (req_word.entry_data == '0);
      push_item.page_size  = req_word.entry_data[PS_BIT];
      push_item.vaddr      = req_word.vaddr;
      push_item.entry_data = req_word.entry_data;
   end

endmodule

// File: rtl/core/fptw_queue.sv
module fptw_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fptw_pkg::push_ctl_type push_ctl,
   input  fptw_pkg::item_type     push_item,
   output logic                   push_ready,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output fptw_pkg::item_type     pop_item
);
   import fptw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_ctl.valid && push_ctl.ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/fptw_back.sv
module fptw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fptw_pkg::PA_W-1:0]   table_base,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  fptw_pkg::item_type          pop_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fptw_pkg::rsp_type           rsp_word
);
   import fptw_pkg::*;

   // walk state: idle, or waiting for the entry of a level
   localparam logic [2:0] LVL_IDLE = 3'd0;
   localparam logic [2:0] LVL_4    = 3'd1;
   localparam logic [2:0] LVL_3    = 3'd2;
   localparam logic [2:0] LVL_2    = 3'd3;
   localparam logic [2:0] LVL_1    = 3'd4;

   localparam int unsigned OFS_W = PA_W - IDX_W - 3;

   logic [2:0]        level_ff, level_in;
   logic [VA_W-1:0]   vaddr_ff, vaddr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;
   logic              pop;
   logic              has_result;
   rsp_type           result;
   logic [PTE_W-1:0]  pte;
   logic [PA_W-1:0]   next_table;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign pte       = pop_item.entry_data;
   assign next_table = {pte[51:12], 12'd0};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // step the walk for the word at the head of the queue
   always_comb begin
      level_in   = level_ff;
      vaddr_in   = vaddr_ff;
      has_result = 1'b0;
      result     = '0;
      if (pop) begin
         if (!pop_item.is_entry) begin
            if (level_ff == LVL_IDLE) begin
               has_result = 1'b1;
               if (table_base == '0) begin
                  result.kind  = KIND_DONE;
                  result.fault = 1'b1;
               end else begin
                  vaddr_in         = pop_item.vaddr;
                  level_in         = LVL_4;
                  result.kind      = KIND_READ;
                  result.read_addr = table_base
                     + {OFS_W'(0), pop_item.vaddr[47:39], 3'd0};
               end
            end
         end else if (level_ff != LVL_IDLE) begin
            has_result = 1'b1;
            if (pop_item.entry_zero) begin
               level_in     = LVL_IDLE;
               result.kind  = KIND_DONE;
               result.fault = 1'b1;
            end else begin
               unique case (level_ff)
                  LVL_4: begin
                     level_in         = LVL_3;
                     result.kind      = KIND_READ;
                     result.read_addr = next_table
                        + {OFS_W'(0), vaddr_ff[38:30], 3'd0};
                  end
                  LVL_3: begin
                     if (pop_item.page_size) begin
                        level_in         = LVL_IDLE;
                        result.kind      = KIND_DONE;
                        result.paddr     = {pte[51:30], vaddr_ff[29:0]};
                     end else begin
                        level_in         = LVL_2;
                        result.kind      = KIND_READ;
                        result.read_addr = next_table
                           + {OFS_W'(0), vaddr_ff[29:21], 3'd0};
                     end
                  end
                  LVL_2: begin
                     if (pop_item.page_size) begin
                        level_in         = LVL_IDLE;
                        result.kind      = KIND_DONE;
                        result.paddr     = {pte[51:21], vaddr_ff[20:0]};
                     end else begin
                        level_in         = LVL_1;
                        result.kind      = KIND_READ;
                        result.read_addr = next_table
                           + {OFS_W'(0), vaddr_ff[20:12], 3'd0};
                     end
                  end
                  LVL_1: begin
                     level_in         = LVL_IDLE;
                     result.kind      = KIND_DONE;
                     result.paddr     = {pte[51:12], vaddr_ff[11:0]};
                  end
                  default: begin
                     level_in   = LVL_IDLE;
                     has_result = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   // load the output register, drop it once taken
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop && has_result) begin
         rsp_word_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LVL_IDLE;
         vaddr_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         vaddr_ff     <= vaddr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: tb/tb_four_level_page_table_walker_top.sv
module tb_four_level_page_table_walker_top;
   import fptw_pkg::*;

   // walker position as the predictor tracks it
   typedef enum logic [2:0] {
      WALK_IDLE,
      WAIT_PML4,
      WAIT_PDPT,
      WAIT_PD,
      WAIT_PT
   } walk_level_type;

   localparam logic [PA_W-1:0] MAX_BASE = 52'hF_FFFF_FFFF_F000;
   localparam int unsigned DRAIN_CYCLES = 12;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_word;
   logic             csr_write_enable = 1'b0;
   logic [PA_W-1:0]  csr_write_data = '0;

   // predictor state
   walk_level_type   walk_lvl = WALK_IDLE;
   logic [VA_W-1:0]  vaddr_reg = '0;
   logic [PA_W-1:0]  base_reg = '0;
   rsp_type          expected_rsp[$];

   int words_sent = 0;
   int burst_left = 0;
   int mismatches = 0;
   int reads_seen = 0;
   int faults_seen = 0;
   int leaf_4k = 0;
   int leaf_2m = 0;
   int leaf_1g = 0;
   int dropped = 0;
   int base_writes = 0;

   // receiver stall pattern
   int seg_left = 0;
   int seg_mode = 0;

   four_level_page_table_walker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // compute the response a request word causes, if any
   function automatic void predict_walk(input req_type w);
      rsp_type r;
      logic    hit;
      r = '0;
      hit = 1'b0;
      if (w.func == FUNC_TRANSLATE) begin
         if (walk_lvl == WALK_IDLE) begin
            hit = 1'b1;
            if (base_reg == '0) begin
               r.kind = KIND_DONE;
               r.fault = 1'b1;
            end else begin
               vaddr_reg = w.vaddr;
               walk_lvl = WAIT_PML4;
               r.kind = KIND_READ;
               r.read_addr = base_reg + PA_W'({vaddr_reg[47:39], 3'b000});
            end
         end
      end else if (walk_lvl != WALK_IDLE) begin
         hit = 1'b1;
         if (w.entry_data == '0) begin
            r.kind = KIND_DONE;
            r.fault = 1'b1;
            walk_lvl = WALK_IDLE;
         end else begin
            case (walk_lvl)
               WAIT_PML4: begin
                  r.kind = KIND_READ;
                  r.read_addr = {w.entry_data[51:12], 12'h000}
                     + PA_W'({vaddr_reg[38:30], 3'b000});
                  walk_lvl = WAIT_PDPT;
               end
               WAIT_PDPT: begin
                  if (w.entry_data[PS_BIT]) begin
                     r.kind = KIND_DONE;
                     r.paddr = {w.entry_data[51:30], 30'h0} + PA_W'(vaddr_reg[29:0]);
                     walk_lvl = WALK_IDLE;
                     leaf_1g++;
                  end else begin
                     r.kind = KIND_READ;
                     r.read_addr = {w.entry_data[51:12], 12'h000}
                        + PA_W'({vaddr_reg[29:21], 3'b000});
                     walk_lvl = WAIT_PD;
                  end
               end
               WAIT_PD: begin
                  if (w.entry_data[PS_BIT]) begin
                     r.kind = KIND_DONE;
                     r.paddr = {w.entry_data[51:21], 21'h0} + PA_W'(vaddr_reg[20:0]);
                     walk_lvl = WALK_IDLE;
                     leaf_2m++;
                  end else begin
                     r.kind = KIND_READ;
                     r.read_addr = {w.entry_data[51:12], 12'h000}
                        + PA_W'({vaddr_reg[20:12], 3'b000});
                     walk_lvl = WAIT_PT;
                  end
               end
               default: begin
                  r.kind = KIND_DONE;
                  r.paddr = {w.entry_data[51:12], 12'h000} + PA_W'(vaddr_reg[11:0]);
                  walk_lvl = WALK_IDLE;
                  leaf_4k++;
               end
            endcase
         end
      end
      if (hit) begin
         expected_rsp.push_back(r);
         if (r.kind == KIND_READ) reads_seen++;
         if (r.fault) faults_seen++;
      end else begin
         dropped++;
      end
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [VA_W-1:0] pick_vaddr();
      int sel;
      logic [63:0] r;
      sel = $urandom_range(0, 99);
      r = rand64();
      if (sel < 10) return '1;
      if (sel < 15) return '0;
      return r[VA_W-1:0];
   endfunction

   // drive one word, wait for acceptance, then insert a gap at burst end
   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_walk(w);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
      end
   endtask

   task automatic send_translate(input logic [VA_W-1:0] va);
      req_type w;
      w = '0;
      w.func = FUNC_TRANSLATE;
      w.vaddr = va;
      w.entry_data = rand64();
      send_word(w);
   endtask

   task automatic send_entry(input logic [PTE_W-1:0] e);
      req_type w;
      logic [63:0] r;
      r = rand64();
      w = '0;
      w.func = FUNC_ENTRY;
      w.vaddr = r[VA_W-1:0];
      w.entry_data = e;
      send_word(w);
   endtask

   // close any open walk, then wait out all responses and the pipeline
   task automatic wait_drain();
      while (walk_lvl != WALK_IDLE) send_entry('0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_base(input logic [PA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      base_reg = value;
      base_writes++;
   endtask

   // base left at its reset value of zero: translation disabled
   task automatic test_disabled_base();
      send_translate('1);
      send_translate('0);
      send_entry('1);
      wait_drain();
   endtask

   task automatic test_directed_walks();
      write_table_base(MAX_BASE);
      // full 4K walk with extreme fields; translate while busy dropped
      send_translate('1);
      send_translate('0);
      send_entry('1);
      send_entry(64'hFFFF_FFFF_FFFF_FF7F);
      send_entry(64'hFFFF_FFFF_FFFF_FF7F);
      send_entry('1);
      wait_drain();

      // unaligned base of one
      write_table_base(52'h1);
      // size bit at the top level means nothing; 1G leaf
      send_translate('0);
      send_entry(64'h80);
      send_entry(64'h8000_0000_0000_0080);
      // 2M leaf
      send_translate(48'h0000_4020_1ABC);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h000F_FFFF_FFE0_0080);
      // zero entry at the top and at the last level
      send_translate(48'h8765_4321_0FED);
      send_entry('0);
      send_translate('1);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry('0);
      // entry while idle dropped
      send_entry(64'h0000_0000_0000_1000);
      wait_drain();
   endtask

   // mostly well-formed walks with random content, some noise words
   task automatic test_random_walks(input logic [PA_W-1:0] base, input int n_words);
      int start;
      int zero_pct;
      int ps_pct;
      logic [PTE_W-1:0] e;
      req_type w;
      write_table_base(base);
      start = words_sent;
      while (words_sent - start < n_words) begin
         if ($urandom_range(0, 99) < 85) begin
            zero_pct = $urandom_range(0, 12);
            ps_pct = $urandom_range(0, 60);
            send_translate(pick_vaddr());
            while (walk_lvl != WALK_IDLE) begin
               e = rand64();
               if ($urandom_range(0, 99) < zero_pct) begin
                  e = '0;
               end else if (walk_lvl == WAIT_PDPT || walk_lvl == WAIT_PD) begin
                  e[PS_BIT] = ($urandom_range(0, 99) < ps_pct);
               end
               send_entry(e);
            end
         end else begin
            w.func = 1'($urandom_range(0, 1));
            w.vaddr = pick_vaddr();
            w.entry_data = ($urandom_range(0, 7) == 0) ? '0 : rand64();
            send_word(w);
         end
      end
      wait_drain();
   endtask

   function automatic logic [PA_W-1:0] pick_base(input logic aligned);
      logic [63:0] r;
      logic [PA_W-1:0] b;
      r = rand64();
      b = r[PA_W-1:0];
      if (aligned) b[11:0] = '0;
      if (b > MAX_BASE) b = MAX_BASE;
      if (b == '0) b = 52'h1000;
      return b;
   endfunction

   // receiver: segments of always-ready, random, sparse and periodic stalls
   always @(posedge clock) begin
      if (seg_left == 0) begin
         seg_mode <= $urandom_range(0, 3);
         seg_left <= $urandom_range(20, 200);
      end else begin
         seg_left <= seg_left - 1;
      end
      case (seg_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (seg_left % 16) < 5;
      endcase
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response word with nothing expected: kind %0d read_addr %h paddr %h",
                   rsp_word.kind, rsp_word.read_addr, rsp_word.paddr);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_word.kind);
               mismatches++;
            end
            if (rsp_word.read_addr !== want.read_addr) begin
               $error("read_addr: expected %h, actual %h", want.read_addr, rsp_word.read_addr);
               mismatches++;
            end
            if (rsp_word.paddr !== want.paddr) begin
               $error("paddr: expected %h, actual %h", want.paddr, rsp_word.paddr);
               mismatches++;
            end
            if (rsp_word.fault !== want.fault) begin
               $error("fault: expected %0d, actual %0d", want.fault, rsp_word.fault);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_base();
      test_directed_walks();
      test_random_walks(pick_base(1'b1), 300);
      test_random_walks(pick_base(1'b0), 250);
      test_random_walks(MAX_BASE, 250);
      test_random_walks(52'h1, 250);
      test_random_walks('0, 150);
      test_random_walks(pick_base(1'b1), 100);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d request words over %0d base settings; %0d dropped, %0d reads",
               words_sent, base_writes, dropped, reads_seen);
      $display("Walks ended in %0d 4K, %0d 2M and %0d 1G leaves and %0d faults",
               leaf_4k, leaf_2m, leaf_1g, faults_seen);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
